/* rtl/mfb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_pkg
// Shared types, constants and helpers of the monochrome framebuffer blitter.
// ----------------------------------------------------------------------------
package mfb_pkg;

  // default store limits
  localparam int CANVAS_MAX_WIDTH_DEF  = 128;
  localparam int CANVAS_MAX_HEIGHT_DEF = 64;
  localparam int SPRITE_MAX_WIDTH_DEF  = 32;
  localparam int SPRITE_MAX_HEIGHT_DEF = 32;

  // pixels packed in one memory word, leftmost pixel in the msb
  localparam int PIXELS_PER_WORD = 8;

  // field and register widths
  localparam int XY_W     = 9;
  localparam int CW_REG_W = 8;
  localparam int CH_REG_W = 7;
  localparam int SW_REG_W = 6;
  localparam int SH_REG_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // internal signed coordinate: offset plus a sprite column over the widest limits
  localparam int COORD_W = 11;
  // size after clamping, holds the largest limit
  localparam int SIZE_W  = 9;

  localparam logic [CW_REG_W-1:0] CANVAS_W_RST = CW_REG_W'(128);
  localparam logic [CH_REG_W-1:0] CANVAS_H_RST = CH_REG_W'(64);
  localparam logic [SW_REG_W-1:0] SPRITE_W_RST = SW_REG_W'(32);
  localparam logic [SH_REG_W-1:0] SPRITE_H_RST = SH_REG_W'(32);

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_BLIT  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CANVAS_W = 2'd0,
    REG_CANVAS_H = 2'd1,
    REG_SPRITE_W = 2'd2,
    REG_SPRITE_H = 2'd3
  } reg_idx_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

  // strict bounds check: 0 <= x < w and 0 <= y < h
  function automatic logic inside_fn(input logic signed [COORD_W-1:0] x,
                                     input logic signed [COORD_W-1:0] y,
                                     input logic [SIZE_W-1:0] w,
                                     input logic [SIZE_W-1:0] h);
    return !x[COORD_W-1] && !y[COORD_W-1] &&
           (x[COORD_W-2:0] < (COORD_W-1)'(w)) &&
           (y[COORD_W-2:0] < (COORD_W-1)'(h));
  endfunction

endpackage

/* rtl/mfb_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module mfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mono_framebuffer_blitter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_framebuffer_blitter
// Two 1 bpp pixel stores (canvas and sprite) with pixel write/read, store clear
// and sprite-to-canvas blit.
//
// A command is taken when start is high and busy is low; its single result
// shows on out_pixel_out/out_in_bounds for one cycle with out_valid and cannot
// be held off. Pixel write and read run a memory read, then modify/write back
// and result. Clear sweeps the chosen store one word per cycle (canvas 1024
// words, sprite 128 words at default limits). Blit visits each sprite pixel in
// use (sizes clamped to the limits) with a read of both stores, then a write
// back of the canvas word; busy stays high until the last write back and the
// result shows as busy drops. An empty sprite gives its result without going
// busy. After reset a clearing pass over both stores runs with busy high.
// Configuration writes are always accepted and must only be issued while idle.
// ----------------------------------------------------------------------------
module mono_framebuffer_blitter #(
  parameter int CANVAS_MAX_WIDTH  = mfb_pkg::CANVAS_MAX_WIDTH_DEF,
  parameter int CANVAS_MAX_HEIGHT = mfb_pkg::CANVAS_MAX_HEIGHT_DEF,
  parameter int SPRITE_MAX_WIDTH  = mfb_pkg::SPRITE_MAX_WIDTH_DEF,
  parameter int SPRITE_MAX_HEIGHT = mfb_pkg::SPRITE_MAX_HEIGHT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_cmd,
  input  logic                                 in_target,
  input  logic signed [mfb_pkg::XY_W-1:0]      in_x_pos,
  input  logic signed [mfb_pkg::XY_W-1:0]      in_y_pos,
  input  logic                                 in_pixel_value,
  output logic                                 out_valid,
  output logic                                 out_pixel_out,
  output logic                                 out_in_bounds,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mfb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mfb_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int PPW     = mfb_pkg::PIXELS_PER_WORD;
  localparam int CSTRIDE = (CANVAS_MAX_WIDTH + PPW - 1) / PPW;
  localparam int SSTRIDE = (SPRITE_MAX_WIDTH + PPW - 1) / PPW;
  localparam int CWORDS  = CSTRIDE * CANVAS_MAX_HEIGHT;
  localparam int SWORDS  = SSTRIDE * SPRITE_MAX_HEIGHT;
  localparam int CAW     = $clog2(CWORDS);
  localparam int SAW     = $clog2(SWORDS);
  localparam int CNTW    = (CAW > SAW) ? CAW : SAW;
  localparam int INIT_LAST = ((CWORDS > SWORDS) ? CWORDS : SWORDS) - 1;
  localparam int BXW     = $clog2(SPRITE_MAX_WIDTH);
  localparam int BYW     = $clog2(SPRITE_MAX_HEIGHT);
  localparam int CW      = mfb_pkg::COORD_W;
  localparam int SZW     = mfb_pkg::SIZE_W;
  localparam int XYW     = mfb_pkg::XY_W;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ACCESS,
    ST_CLEAR,
    ST_BLIT_RD,
    ST_BLIT_WR
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [mfb_pkg::CW_REG_W-1:0] canvas_w_r;
  logic [mfb_pkg::CH_REG_W-1:0] canvas_h_r;
  logic [mfb_pkg::SW_REG_W-1:0] sprite_w_r;
  logic [mfb_pkg::SH_REG_W-1:0] sprite_h_r;

  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [BXW-1:0]  bx_r, bx_nxt;
  logic [BYW-1:0]  by_r, by_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_pix_r, out_pix_nxt;
  logic            out_ib_r, out_ib_nxt;

  // pixel access transaction
  logic            acc_wr_r, acc_wr_nxt;
  logic            acc_tgt_r, acc_tgt_nxt;
  logic            acc_val_r, acc_val_nxt;
  logic            acc_ok_r, acc_ok_nxt;
  logic [2:0]      acc_bit_r, acc_bit_nxt;
  logic [CAW-1:0]  acc_caddr_r, acc_caddr_nxt;
  logic [SAW-1:0]  acc_saddr_r, acc_saddr_nxt;

  // blit transaction
  logic signed [XYW-1:0] blt_x_r, blt_x_nxt;
  logic signed [XYW-1:0] blt_y_r, blt_y_nxt;
  logic [CAW-1:0]  blt_caddr_r, blt_caddr_nxt;
  logic            blt_cok_r, blt_cok_nxt;
  logic [2:0]      blt_sbit_r, blt_sbit_nxt;
  logic [2:0]      blt_cbit_r, blt_cbit_nxt;

  // memory ports
  logic            c_we, s_we;
  logic [CAW-1:0]  c_waddr, c_raddr;
  logic [SAW-1:0]  s_waddr, s_raddr;
  logic [PPW-1:0]  c_wdata, s_wdata, c_rdata, s_rdata;

  logic [SZW-1:0]  cw_eff, ch_eff, sw_eff, sh_eff;
  logic signed [CW-1:0] ix, iy, bcx, bcy;
  logic            in_ok;
  logic [CAW-1:0]  in_caddr, bcaddr;
  logic [SAW-1:0]  in_saddr, bsaddr;
  logic            bcok;
  logic [PPW-1:0]  acc_word, acc_mod, blt_mod;
  logic            blt_pix;

  assign cw_eff = mfb_pkg::clamp_size(SZW'(canvas_w_r), SZW'(CANVAS_MAX_WIDTH));
  assign ch_eff = mfb_pkg::clamp_size(SZW'(canvas_h_r), SZW'(CANVAS_MAX_HEIGHT));
  assign sw_eff = mfb_pkg::clamp_size(SZW'(sprite_w_r), SZW'(SPRITE_MAX_WIDTH));
  assign sh_eff = mfb_pkg::clamp_size(SZW'(sprite_h_r), SZW'(SPRITE_MAX_HEIGHT));

  // command coordinates
  assign ix = {{(CW-XYW){in_x_pos[XYW-1]}}, in_x_pos};
  assign iy = {{(CW-XYW){in_y_pos[XYW-1]}}, in_y_pos};
  assign in_ok = in_target ? mfb_pkg::inside_fn(ix, iy, sw_eff, sh_eff)
                           : mfb_pkg::inside_fn(ix, iy, cw_eff, ch_eff);
  // addresses are only meaningful when the coordinate is inside
  assign in_caddr = CAW'(int'(iy[CW-2:0]) * CSTRIDE + int'(ix[CW-2:3]));
  assign in_saddr = SAW'(int'(iy[CW-2:0]) * SSTRIDE + int'(ix[CW-2:3]));

  // blit coordinates
  assign bcx = {{(CW-XYW){blt_x_r[XYW-1]}}, blt_x_r} + {{(CW-BXW){1'b0}}, bx_r};
  assign bcy = {{(CW-XYW){blt_y_r[XYW-1]}}, blt_y_r} + {{(CW-BYW){1'b0}}, by_r};
  assign bcok   = mfb_pkg::inside_fn(bcx, bcy, cw_eff, ch_eff);
  assign bcaddr = CAW'(int'(bcy[CW-2:0]) * CSTRIDE + int'(bcx[CW-2:3]));
  assign bsaddr = SAW'(int'(by_r) * SSTRIDE + int'(bx_r >> 3));

  assign c_raddr = (state_r == ST_BLIT_RD) ? bcaddr : in_caddr;
  assign s_raddr = (state_r == ST_BLIT_RD) ? bsaddr : in_saddr;

  // read-modify-write data paths
  always_comb begin
    acc_word = acc_tgt_r ? s_rdata : c_rdata;
    acc_mod  = acc_word;
    acc_mod[~acc_bit_r] = acc_val_r;
    blt_pix  = s_rdata[~blt_sbit_r];
    blt_mod  = c_rdata;
    blt_mod[~blt_cbit_r] = blt_pix;
  end

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pix_r;
  assign out_in_bounds = out_ib_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    out_valid_nxt = 1'b0;
    out_pix_nxt   = out_pix_r;
    out_ib_nxt    = out_ib_r;
    acc_wr_nxt    = acc_wr_r;
    acc_tgt_nxt   = acc_tgt_r;
    acc_val_nxt   = acc_val_r;
    acc_ok_nxt    = acc_ok_r;
    acc_bit_nxt   = acc_bit_r;
    acc_caddr_nxt = acc_caddr_r;
    acc_saddr_nxt = acc_saddr_r;
    blt_x_nxt     = blt_x_r;
    blt_y_nxt     = blt_y_r;
    blt_caddr_nxt = blt_caddr_r;
    blt_cok_nxt   = blt_cok_r;
    blt_sbit_nxt  = blt_sbit_r;
    blt_cbit_nxt  = blt_cbit_r;
    c_we    = 1'b0;
    c_waddr = acc_caddr_r;
    c_wdata = acc_mod;
    s_we    = 1'b0;
    s_waddr = acc_saddr_r;
    s_wdata = acc_mod;

    case (state_r)
      ST_INIT: begin
        c_we    = (int'(cnt_r) < CWORDS);
        c_waddr = cnt_r[CAW-1:0];
        c_wdata = '0;
        s_we    = (int'(cnt_r) < SWORDS);
        s_waddr = cnt_r[SAW-1:0];
        s_wdata = '0;
        if (int'(cnt_r) == INIT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (start) begin
          case (mfb_pkg::cmd_t'(in_cmd))
            mfb_pkg::CMD_WRITE, mfb_pkg::CMD_READ: begin
              acc_wr_nxt    = (in_cmd == mfb_pkg::CMD_WRITE);
              acc_tgt_nxt   = in_target;
              acc_val_nxt   = in_pixel_value;
              acc_ok_nxt    = in_ok;
              acc_bit_nxt   = ix[2:0];
              acc_caddr_nxt = in_caddr;
              acc_saddr_nxt = in_saddr;
              state_nxt     = ST_ACCESS;
            end
            mfb_pkg::CMD_CLEAR: begin
              acc_tgt_nxt = in_target;
              cnt_nxt     = '0;
              state_nxt   = ST_CLEAR;
            end
            mfb_pkg::CMD_BLIT: begin
              blt_x_nxt = in_x_pos;
              blt_y_nxt = in_y_pos;
              bx_nxt    = '0;
              by_nxt    = '0;
              if (sw_eff == '0 || sh_eff == '0) begin
                out_valid_nxt = 1'b1;
                out_pix_nxt   = 1'b0;
                out_ib_nxt    = 1'b0;
              end else begin
                state_nxt = ST_BLIT_RD;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_ACCESS: begin
        c_we          = acc_wr_r && acc_ok_r && !acc_tgt_r;
        s_we          = acc_wr_r && acc_ok_r && acc_tgt_r;
        out_valid_nxt = 1'b1;
        out_pix_nxt   = !acc_wr_r && acc_ok_r && acc_word[~acc_bit_r];
        out_ib_nxt    = acc_ok_r;
        state_nxt     = ST_IDLE;
      end

      ST_CLEAR: begin
        c_we    = !acc_tgt_r;
        c_waddr = cnt_r[CAW-1:0];
        c_wdata = '0;
        s_we    = acc_tgt_r;
        s_waddr = cnt_r[SAW-1:0];
        s_wdata = '0;
        if (int'(cnt_r) == (acc_tgt_r ? SWORDS - 1 : CWORDS - 1)) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = 1'b0;
          out_ib_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_BLIT_RD: begin
        blt_caddr_nxt = bcaddr;
        blt_cok_nxt   = bcok;
        blt_sbit_nxt  = bx_r[2:0];
        blt_cbit_nxt  = bcx[2:0];
        state_nxt     = ST_BLIT_WR;
      end

      ST_BLIT_WR: begin
        // write lands before the next canvas read is issued, so no forwarding
        c_we      = blt_cok_r;
        c_waddr   = blt_caddr_r;
        c_wdata   = blt_mod;
        state_nxt = ST_BLIT_RD;
        if (SZW'(bx_r) == sw_eff - SZW'(1)) begin
          bx_nxt = '0;
          if (SZW'(by_r) == sh_eff - SZW'(1)) begin
            out_valid_nxt = 1'b1;
            out_pix_nxt   = 1'b0;
            out_ib_nxt    = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            by_nxt = by_r + 1'b1;
          end
        end else begin
          bx_nxt = bx_r + 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      bx_r        <= '0;
      by_r        <= '0;
      out_valid_r <= 1'b0;
      canvas_w_r  <= mfb_pkg::CANVAS_W_RST;
      canvas_h_r  <= mfb_pkg::CANVAS_H_RST;
      sprite_w_r  <= mfb_pkg::SPRITE_W_RST;
      sprite_h_r  <= mfb_pkg::SPRITE_H_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      bx_r        <= bx_nxt;
      by_r        <= by_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (mfb_pkg::reg_idx_t'(cfg_index))
          mfb_pkg::REG_CANVAS_W: canvas_w_r <= cfg_data[mfb_pkg::CW_REG_W-1:0];
          mfb_pkg::REG_CANVAS_H: canvas_h_r <= cfg_data[mfb_pkg::CH_REG_W-1:0];
          mfb_pkg::REG_SPRITE_W: sprite_w_r <= cfg_data[mfb_pkg::SW_REG_W-1:0];
          mfb_pkg::REG_SPRITE_H: sprite_h_r <= cfg_data[mfb_pkg::SH_REG_W-1:0];
          default: begin
          end
        endcase
      end
    end
    // payload registers, no reset
    out_pix_r   <= out_pix_nxt;
    out_ib_r    <= out_ib_nxt;
    acc_wr_r    <= acc_wr_nxt;
    acc_tgt_r   <= acc_tgt_nxt;
    acc_val_r   <= acc_val_nxt;
    acc_ok_r    <= acc_ok_nxt;
    acc_bit_r   <= acc_bit_nxt;
    acc_caddr_r <= acc_caddr_nxt;
    acc_saddr_r <= acc_saddr_nxt;
    blt_x_r     <= blt_x_nxt;
    blt_y_r     <= blt_y_nxt;
    blt_caddr_r <= blt_caddr_nxt;
    blt_cok_r   <= blt_cok_nxt;
    blt_sbit_r  <= blt_sbit_nxt;
    blt_cbit_r  <= blt_cbit_nxt;
  end

  mfb_ram #(
    .WIDTH (PPW),
    .DEPTH (CWORDS)
  ) u_canvas_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  mfb_ram #(
    .WIDTH (PPW),
    .DEPTH (SWORDS)
  ) u_sprite_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

endmodule

/* rtl/mfb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_checker
// Port-level temporal checks of the framebuffer blitter, bound to the top level.
// ----------------------------------------------------------------------------
module mfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_cmd,
  input logic       out_valid,
  input logic       out_pixel_out,
  input logic       out_in_bounds
);

  logic accept;
  assign accept = start && !busy;

  // only an empty-sprite blit can finish without going busy
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_cmd != mfb_pkg::CMD_BLIT) |=> busy)
    else $error("command transaction did not raise busy");

  // pixel read and write deliver their result after the access state, which cannot stall
  a_pixel_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_cmd == mfb_pkg::CMD_WRITE || in_cmd == mfb_pkg::CMD_READ)
      |-> ##2 out_valid)
    else $error("pixel transaction result missing");

  a_pixel_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pixel_out |-> out_in_bounds)
    else $error("pixel returned for out of bounds coordinate");

  // clearing pass keeps the block busy right after reset
  a_init_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> busy)
    else $error("block idle during post-reset clearing pass");

endmodule

bind mono_framebuffer_blitter mfb_checker u_mfb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_cmd        (in_cmd),
  .out_valid     (out_valid),
  .out_pixel_out (out_pixel_out),
  .out_in_bounds (out_in_bounds)
);
